// ===== rtl/core/pmuw_pkg.sv =====
`default_nettype none
package pmuw_pkg;

    // fixed widths of the block
    localparam int CELL_BITS    = 23;
    localparam int NUM_AXES     = 3;
    localparam int CFG_IDX_BITS = 2;

    // cell length after reset: 100 angstrom in 1/256 units
    localparam logic [CELL_BITS-1:0] CELL_LEN_RESET = 23'd25600;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_CELL_LEN_X = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_CELL_LEN_Y = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_CELL_LEN_Z = 2'd2;

    // top level sequencing
    typedef enum logic {
        TOP_IDLE,
        TOP_BUSY
    } pmuw_top_state_t;

    // per-axis lane phases
    typedef enum logic [2:0] {
        LN_IDLE,
        LN_PICK,
        LN_DIV,
        LN_FIX,
        LN_DONE
    } pmuw_lane_phase_t;

    // control from the top level to every lane
    typedef struct packed {
        logic load;
        logic take;
    } pmuw_lane_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/core/pmuw_lane.sv =====
`default_nettype none
module pmuw_lane #(
    parameter int COORD_BITS = 24
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire  pmuw_pkg::pmuw_lane_ctl_t ctl,
    input  wire  [COORD_BITS-1:0]        x_in,
    input  wire                          start_in,
    input  wire  [pmuw_pkg::CELL_BITS-1:0] cell_len,
    output logic                         done,
    output logic [COORD_BITS-1:0]        res
);
    import pmuw_pkg::*;

    // working width: covers 2x + L, x +- L and the molecule shift
    localparam int W     = ((COORD_BITS + 1 > CELL_BITS + 1) ? COORD_BITS + 1 : CELL_BITS + 1) + 1;
    localparam int CNT_W = $clog2(W);
    localparam int RW    = CELL_BITS + 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(W - 1);

    pmuw_lane_phase_t phase_reg, phase_next;

    logic [COORD_BITS-1:0] x_reg, x_next;
    logic                  start_reg, start_next;
    logic [COORD_BITS-1:0] ref_reg, ref_next;
    logic signed [W-1:0]   shift_reg, shift_next;
    logic signed [W-1:0]   pos_reg, pos_next;
    logic [W-1:0]          num_sh_reg, num_sh_next;
    logic [W-1:0]          nsave_reg, nsave_next;
    logic [RW-1:0]         rem_reg, rem_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  neg_reg, neg_next;

    logic signed [W-1:0] x_w, ref_w, len_w, x2_w;
    logic signed [W-1:0] lo_w, up_w, d0, d1, d2;
    logic [W-1:0]        a0, a1, a2;
    logic signed [W-1:0] near_w;
    logic                above, below;
    logic [W-1:0]        num_w;
    logic [RW:0]         trial, div_w;
    logic [W-1:0]        diff_w;
    logic [W-2:0]        nl_w;
    logic signed [W:0]   sum_w;

    // sign extension of the coordinates, zero extension of the cell length
    assign x_w   = {{(W-COORD_BITS){x_reg[COORD_BITS-1]}}, x_reg};
    assign ref_w = {{(W-COORD_BITS){ref_reg[COORD_BITS-1]}}, ref_reg};
    assign len_w = {{(W-CELL_BITS){1'b0}}, cell_len};
    assign x2_w  = x_w <<< 1;

    // nearest of x, x-L, x+L to the reference, earlier wins a tie
    assign lo_w = x_w - len_w;
    assign up_w = x_w + len_w;
    assign d0   = x_w - ref_w;
    assign d1   = lo_w - ref_w;
    assign d2   = up_w - ref_w;
    assign a0   = d0[W-1] ? W'(-d0) : W'(d0);
    assign a1   = d1[W-1] ? W'(-d1) : W'(d1);
    assign a2   = d2[W-1] ? W'(-d2) : W'(d2);

    always_comb begin
        near_w = x_w;
        if (a1 < a0) begin
            near_w = lo_w;
            if (a2 < a1) begin
                near_w = up_w;
            end
        end else if (a2 < a0) begin
            near_w = up_w;
        end
    end

    // out of [-L/2, L/2] test and numerator |2x| + L - 1 of the shift count
    assign above = (x2_w > len_w) && (cell_len != '0);
    assign below = (x2_w < -len_w) && (cell_len != '0);
    assign num_w = above ? W'(x2_w + len_w - W'(1)) : W'(-x2_w + len_w - W'(1));

    // one restoring step of the remainder by 2L
    assign trial = {rem_reg, num_sh_reg[W-1]};
    assign div_w = {1'b0, cell_len, 1'b0};

    // n*L = (N - r) / 2
    assign diff_w = nsave_reg - {{(W-RW){1'b0}}, rem_reg};
    assign nl_w   = diff_w[W-1:1];

    // phase sequencing and datapath updates
    always_comb begin
        phase_next  = phase_reg;
        x_next      = x_reg;
        start_next  = start_reg;
        ref_next    = ref_reg;
        shift_next  = shift_reg;
        pos_next    = pos_reg;
        num_sh_next = num_sh_reg;
        nsave_next  = nsave_reg;
        rem_next    = rem_reg;
        cnt_next    = cnt_reg;
        neg_next    = neg_reg;
        case (phase_reg)
            LN_IDLE: begin
                if (ctl.load) begin
                    x_next     = x_in;
                    start_next = start_in;
                    phase_next = LN_PICK;
                end
            end
            LN_PICK: begin
                if (start_reg) begin
                    ref_next = x_reg;
                    pos_next = x_w;
                    if (above || below) begin
                        num_sh_next = num_w;
                        nsave_next  = num_w;
                        rem_next    = '0;
                        cnt_next    = '0;
                        neg_next    = above;
                        phase_next  = LN_DIV;
                    end else begin
                        shift_next = '0;
                        phase_next = LN_DONE;
                    end
                end else begin
                    pos_next   = near_w;
                    phase_next = LN_DONE;
                end
            end
            LN_DIV: begin
                if (trial >= div_w) begin
                    rem_next = RW'(trial - div_w);
                end else begin
                    rem_next = RW'(trial);
                end
                num_sh_next = num_sh_reg << 1;
                cnt_next    = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_LAST) begin
                    phase_next = LN_FIX;
                end
            end
            LN_FIX: begin
                if (neg_reg) begin
                    shift_next = -$signed({1'b0, nl_w});
                end else begin
                    shift_next = $signed({1'b0, nl_w});
                end
                phase_next = LN_DONE;
            end
            LN_DONE: begin
                if (ctl.take) begin
                    phase_next = LN_IDLE;
                end
            end
            default: begin
                phase_next = LN_IDLE;
            end
        endcase
    end

    // molecule state and phase
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= LN_IDLE;
            ref_reg   <= '0;
            shift_reg <= '0;
        end else begin
            phase_reg <= phase_next;
            ref_reg   <= ref_next;
            shift_reg <= shift_next;
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        x_reg      <= x_next;
        start_reg  <= start_next;
        pos_reg    <= pos_next;
        num_sh_reg <= num_sh_next;
        nsave_reg  <= nsave_next;
        rem_reg    <= rem_next;
        cnt_reg    <= cnt_next;
        neg_reg    <= neg_next;
    end

    // apply the shift and clamp to the coordinate range
    assign sum_w = {pos_reg[W-1], pos_reg} + {shift_reg[W-1], shift_reg};

    always_comb begin
        if ((&sum_w[W:COORD_BITS-1]) || !(|sum_w[W:COORD_BITS-1])) begin
            res = sum_w[COORD_BITS-1:0];
        end else if (sum_w[W]) begin
            res = {1'b1, {(COORD_BITS-1){1'b0}}};
        end else begin
            res = {1'b0, {(COORD_BITS-1){1'b1}}};
        end
    end

    assign done = (phase_reg == LN_DONE);

endmodule
`default_nettype wire

// ===== rtl/core/molecule_periodic_unwrap_wrap_unit.sv =====
// path: an atom inside a molecule or a molecule start already within half a cell
//   passes lane pick, lane done and the output register; a start that needs a
//   shift also passes the bit-serial remainder unit over a W-bit numerator and
//   lane fix (W = max(COORD_BITS, 23) + 2); one item is in work at a time, and
//   the three axis lanes run together and the slowest lane sets the pace
// reset: aresetn synchronous active low; cell lengths return to 25600, reference
//   and shift to zero, both channels empty
`default_nettype none
module molecule_periodic_unwrap_wrap_unit #(
    parameter int COORD_BITS = 24
) (
    input  wire                                    aclk,
    input  wire                                    aresetn,
    // pos_x, pos_y, pos_z from bit 0 up, zero padded to bytes
    input  wire  [((3*COORD_BITS+7)/8)*8-1:0]      s_tdata,
    // starts_molecule
    input  wire                                    s_tuser,
    input  wire                                    s_tvalid,
    output logic                                   s_tready,
    // out_x, out_y, out_z from bit 0 up, zero padded to bytes
    output logic [((3*COORD_BITS+7)/8)*8-1:0]      m_tdata,
    output logic                                   m_tvalid,
    input  wire                                    m_tready,
    input  wire                                    cfg_valid,
    output logic                                   cfg_ready,
    input  wire  [pmuw_pkg::CFG_IDX_BITS-1:0]      cfg_index,
    input  wire  [pmuw_pkg::CELL_BITS-1:0]         cfg_data
);
    import pmuw_pkg::*;

    localparam int DW = ((3*COORD_BITS+7)/8)*8;

    pmuw_top_state_t state_reg, state_next;

    logic [CELL_BITS-1:0]    cell_len_reg [NUM_AXES];
    logic [3*COORD_BITS-1:0] out_data_reg;
    logic                    out_valid_reg, out_valid_next;
    logic [NUM_AXES-1:0]     lane_done;
    logic [COORD_BITS-1:0]   lane_res [NUM_AXES];
    pmuw_lane_ctl_t          lane_ctl;
    logic                    in_accept;
    logic                    out_load;

    // configuration registers, index beyond the list is dropped
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int a = 0; a < NUM_AXES; a++) begin
                cell_len_reg[a] <= CELL_LEN_RESET;
            end
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_CELL_LEN_X: cell_len_reg[0] <= cfg_data;
                REG_CELL_LEN_Y: cell_len_reg[1] <= cfg_data;
                REG_CELL_LEN_Z: cell_len_reg[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    // axis lanes
    for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
        pmuw_lane #(
            .COORD_BITS(COORD_BITS)
        ) u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctl     (lane_ctl),
            .x_in    (s_tdata[a*COORD_BITS +: COORD_BITS]),
            .start_in(s_tuser),
            .cell_len(cell_len_reg[a]),
            .done    (lane_done[a]),
            .res     (lane_res[a])
        );
    end

    // item sequencing and merge of the lane results
    always_comb begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        s_tready       = 1'b0;
        out_load       = 1'b0;
        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            TOP_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    state_next = TOP_BUSY;
                end
            end
            TOP_BUSY: begin
                if ((&lane_done) && (!out_valid_reg || m_tready)) begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = TOP_IDLE;
                end
            end
            default: begin
                state_next = TOP_IDLE;
            end
        endcase
    end

    assign in_accept     = s_tvalid && s_tready;
    assign lane_ctl.load = in_accept;
    assign lane_ctl.take = out_load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= TOP_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_data_reg <= {lane_res[2], lane_res[1], lane_res[0]};
        end
    end

    assign m_tdata  = DW'(out_data_reg);
    assign m_tvalid = out_valid_reg;

`ifndef SYNTHESIS
    // results are taken from the lanes only once all three have finished
    a_take_all_done: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (&lane_done))
        else $error("lane result taken before all lanes finished");

    // a waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        !(out_load && out_valid_reg && !m_tready))
        else $error("output register overwritten while stalled");

    // one item in work at a time
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept |=> !s_tready)
        else $error("second item accepted while one is in work");
`endif

endmodule
`default_nettype wire
